// File: rtl/core/dwdc_pkg.sv
// Shared types and constants for the depthwise 3x3 transposed convolution accumulator.
// No dependencies; the top level and dwdc_mult in rtl/core import this package.
package dwdc_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int ACC_W       = 36;
  localparam int MULT_W      = 17;
  localparam int PROD_W      = 2 * MULT_W;
  localparam int ROW_ADDR_W  = 17;
  localparam int KERNEL_TAPS = 9;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 8;

  localparam logic [1:0] REQ_WEIGHT = 2'd0;
  localparam logic [1:0] REQ_PIXEL  = 2'd1;
  localparam logic [1:0] REQ_READ   = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_STRIDE_TWO = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_HEIGHT  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH  = 3'd4;

  localparam logic [3:0] LAST_TAP = 4'd8;
  localparam logic [1:0] LAST_COL = 2'd2;

  typedef enum logic [7:0] {
    ST_CLEAR = 8'b0000_0001,
    ST_IDLE  = 8'b0000_0010,
    ST_BASE  = 8'b0000_0100,
    ST_TAP   = 8'b0000_1000,
    ST_TOTAL = 8'b0001_0000,
    ST_READ  = 8'b0010_0000,
    ST_OUT   = 8'b0100_0000
  } state_t;

endpackage

// File: rtl/core/depthwise_deconv3x3_accumulator_unit.sv
// Top level of the depthwise 3x3 transposed convolution accumulator: sequencer and datapath.
// Depends on dwdc_pkg, dwdc_mult and dwdc_ram.
//
//   channel   | signals                                         | handshake
//   ----------+-------------------------------------------------+------------------------
//   request   | req_type, weight_index, sample_value            | start && !busy
//   result    | result_value, last_of_plane                     | result_valid, one cycle
//   config    | cfg_index, cfg_data                             | cfg_valid && cfg_ready
//
// A weight load never raises busy. A pixel holds busy for one multiply for the row base
// address and then nine taps, each a product on the shared multiplier and a read-modify-write
// of the store; the next request is taken only once busy drops. A read holds busy through a
// plane size multiply, a store read and a clear, and its result appears on the cycle after the
// clear. After reset busy stays high while the whole store is cleared. Config beats are taken
// only when idle.
module depthwise_deconv3x3_accumulator_unit #(
  parameter int MAX_OUT_DIM = 128
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic [1:0]                             req_type,
  input  logic [3:0]                             weight_index,
  input  logic signed [dwdc_pkg::SAMPLE_W-1:0]   sample_value,
  output logic                                   result_valid,
  output logic signed [dwdc_pkg::ACC_W-1:0]      result_value,
  output logic                                   last_of_plane,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [dwdc_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dwdc_pkg::CFG_DATA_W-1:0]        cfg_data
);
  import dwdc_pkg::*;

  localparam int DEPTH   = MAX_OUT_DIM * MAX_OUT_DIM;
  localparam int AW      = $clog2(DEPTH);
  localparam int DIM_CAP = (MAX_OUT_DIM > 255) ? 255 : MAX_OUT_DIM;
  localparam logic [7:0] DIM_CAP8 = 8'(DIM_CAP);
  localparam int TOT_W   = 17;
  localparam int CW      = ((AW > TOT_W) ? AW : TOT_W) + 1;
  localparam logic [AW-1:0] CLR_LAST = AW'(DEPTH - 1);

  state_t state;

  logic       stride_two;
  logic [6:0] in_height;
  logic [6:0] in_width;
  logic [7:0] out_height;
  logic [7:0] out_width;

  logic signed [SAMPLE_W-1:0] weights [KERNEL_TAPS];
  logic [6:0]    pixel_row;
  logic [6:0]    pixel_col;
  logic [AW-1:0] drain_pointer;
  logic [AW-1:0] clr_addr;

  logic [3:0] tap_k;
  logic [1:0] tap_r;
  logic [1:0] tap_c;

  logic signed [SAMPLE_W-1:0] pix;
  logic [7:0]            orow0;
  logic [7:0]            ocol0;
  logic [ROW_ADDR_W-1:0] row_addr;
  logic                  wb_en;
  logic [AW-1:0]         wb_addr;
  logic [AW-1:0]         rd_ptr;
  logic                  last_q;

  logic [7:0] oh;
  logic [7:0] ow;
  logic [6:0] ih;
  logic [6:0] iw;
  logic [7:0] col_inc;
  logic [7:0] row_inc;
  logic [6:0] col_adv;
  logic [6:0] row_adv;

  logic [ROW_ADDR_W-1:0] cur_row;
  logic [ROW_ADDR_W-1:0] tap_addr_full;
  logic [AW-1:0]         tap_addr;
  logic                  tap_ok;

  logic [TOT_W-1:0] total;
  logic [AW-1:0]    ptr_eff;
  logic             last_hit;

  logic signed [MULT_W-1:0] mult_a;
  logic signed [MULT_W-1:0] mult_b;
  logic signed [PROD_W-1:0] mult_q;

  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [ACC_W-1:0] ram_wdata;
  logic [AW-1:0]    ram_raddr;
  logic [ACC_W-1:0] ram_rdata;
  logic [ACC_W-1:0] acc_sum;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = (state == ST_IDLE) && !start;

  always_comb begin
    oh = (out_height == 8'd0) ? 8'd1 : ((out_height > DIM_CAP8) ? DIM_CAP8 : out_height);
    ow = (out_width == 8'd0) ? 8'd1 : ((out_width > DIM_CAP8) ? DIM_CAP8 : out_width);
    ih = (in_height == 7'd0) ? 7'd1 : in_height;
    iw = (in_width == 7'd0) ? 7'd1 : in_width;
  end

  always_comb begin
    col_inc = {1'b0, pixel_col} + 8'd1;
    if (col_inc >= {1'b0, iw}) begin
      col_adv = 7'd0;
      row_inc = {1'b0, pixel_row} + 8'd1;
    end else begin
      col_adv = col_inc[6:0];
      row_inc = {1'b0, pixel_row};
    end
    row_adv = (row_inc >= {1'b0, ih}) ? 7'd0 : row_inc[6:0];
  end

  always_comb begin
    cur_row       = (tap_k == 4'd0) ? mult_q[ROW_ADDR_W-1:0] : row_addr;
    tap_addr_full = cur_row + ROW_ADDR_W'(ocol0) + ROW_ADDR_W'(tap_c);
    tap_addr      = AW'(tap_addr_full);
    tap_ok        = (({1'b0, orow0} + 9'(tap_r)) < {1'b0, oh}) &&
                    (({1'b0, ocol0} + 9'(tap_c)) < {1'b0, ow});
  end

  always_comb begin
    total    = mult_q[TOT_W-1:0];
    ptr_eff  = (CW'(drain_pointer) >= CW'(total)) ? '0 : drain_pointer;
    last_hit = ((CW'(ptr_eff) + CW'(1)) == CW'(total));
  end

  always_comb begin
    mult_a = '0;
    mult_b = '0;
    unique case (state)
      ST_BASE: begin
        mult_a = MULT_W'(orow0);
        mult_b = MULT_W'(ow);
      end
      ST_TAP: begin
        mult_a = MULT_W'(pix);
        mult_b = MULT_W'(weights[tap_k]);
      end
      ST_TOTAL: begin
        mult_a = MULT_W'(oh);
        mult_b = MULT_W'(ow);
      end
      default: begin
        mult_a = '0;
        mult_b = '0;
      end
    endcase
  end

  dwdc_mult u_mult (
    .clk    (clk),
    .op_a   (mult_a),
    .op_b   (mult_b),
    .product(mult_q)
  );

  assign acc_sum = ram_rdata + {{(ACC_W-PROD_W){mult_q[PROD_W-1]}}, mult_q};

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = wb_addr;
    ram_wdata = acc_sum;
    priority if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr;
      ram_wdata = '0;
    end else if (wb_en) begin
      ram_we    = 1'b1;
      ram_waddr = wb_addr;
      ram_wdata = acc_sum;
    end else if (state == ST_OUT) begin
      ram_we    = 1'b1;
      ram_waddr = rd_ptr;
      ram_wdata = '0;
    end
    ram_raddr = (state == ST_READ) ? ptr_eff : tap_addr;
  end

  dwdc_ram #(
    .WIDTH(ACC_W),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      clr_addr      <= '0;
      stride_two    <= 1'b0;
      in_height     <= 7'd1;
      in_width      <= 7'd1;
      out_height    <= 8'd3;
      out_width     <= 8'd3;
      for (int i = 0; i < KERNEL_TAPS; i++) begin
        weights[i] <= '0;
      end
      pixel_row     <= '0;
      pixel_col     <= '0;
      drain_pointer <= '0;
      tap_k         <= '0;
      tap_r         <= '0;
      tap_c         <= '0;
      wb_en         <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      wb_en        <= 1'b0;
      result_valid <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_STRIDE_TWO: stride_two <= cfg_data[0];
          CFG_IN_HEIGHT:  in_height  <= cfg_data[6:0];
          CFG_IN_WIDTH:   in_width   <= cfg_data[6:0];
          CFG_OUT_HEIGHT: out_height <= cfg_data;
          CFG_OUT_WIDTH:  out_width  <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == CLR_LAST) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            unique case (req_type)
              REQ_WEIGHT: begin
                if (weight_index <= LAST_TAP) begin
                  weights[weight_index] <= sample_value;
                end
              end
              REQ_PIXEL: begin
                pixel_row <= row_adv;
                pixel_col <= col_adv;
                tap_k     <= '0;
                tap_r     <= '0;
                tap_c     <= '0;
                state     <= ST_BASE;
              end
              REQ_READ: state <= ST_TOTAL;
              default: ;
            endcase
          end
        end
        ST_BASE: state <= ST_TAP;
        ST_TAP: begin
          wb_en <= tap_ok;
          tap_k <= tap_k + 4'd1;
          if (tap_c == LAST_COL) begin
            tap_c <= '0;
            tap_r <= tap_r + 2'd1;
          end else begin
            tap_c <= tap_c + 2'd1;
          end
          if (tap_k == LAST_TAP) begin
            state <= ST_IDLE;
          end
        end
        ST_TOTAL: state <= ST_READ;
        ST_READ:  state <= ST_OUT;
        ST_OUT: begin
          result_valid  <= 1'b1;
          drain_pointer <= last_q ? '0 : rd_ptr + AW'(1);
          state         <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_IDLE) && start && (req_type == REQ_PIXEL)) begin
      pix   <= sample_value;
      orow0 <= stride_two ? {pixel_row, 1'b0} : {1'b0, pixel_row};
      ocol0 <= stride_two ? {pixel_col, 1'b0} : {1'b0, pixel_col};
    end
    if (state == ST_TAP) begin
      wb_addr  <= tap_addr;
      row_addr <= (tap_c == LAST_COL) ? cur_row + ROW_ADDR_W'(ow) : cur_row;
    end
    if (state == ST_READ) begin
      rd_ptr <= ptr_eff;
      last_q <= last_hit;
    end
    if (state == ST_OUT) begin
      result_value  <= $signed(ram_rdata);
      last_of_plane <= last_q;
    end
  end

  a_result_after_out: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(state == ST_OUT))
    else $error("Result strobe without a preceding output state.");

  a_no_accum_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !wb_en)
    else $error("Accumulation write during the clearing pass.");

  a_tap_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TAP) |-> (tap_k <= LAST_TAP))
    else $error("Tap counter beyond the kernel.");

  a_last_wraps: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last_of_plane) |-> (drain_pointer == '0))
    else $error("Drain pointer did not return to zero after the last element.");

endmodule

// File: rtl/core/dwdc_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// No dependencies.
module dwdc_ram #(
  parameter int WIDTH = 36,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/dwdc_mult.sv
// Shared signed multiplier with a registered product, time-shared by the sequencer.
// Depends on dwdc_pkg for operand and product widths.
module dwdc_mult (
  input  logic                                clk,
  input  logic signed [dwdc_pkg::MULT_W-1:0]  op_a,
  input  logic signed [dwdc_pkg::MULT_W-1:0]  op_b,
  output logic signed [dwdc_pkg::PROD_W-1:0]  product
);
  import dwdc_pkg::*;

  always_ff @(posedge clk) begin
    product <= op_a * op_b;
  end

endmodule

// File: dv/testbench.sv
// Self-checking bench for depthwise_deconv3x3_accumulator_unit: weight loads, pixels and reads
// are compared against an internal prediction of the accumulation plane. Depends on dwdc_pkg.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import dwdc_pkg::*;

  localparam int MAX_DIM = 128;
  localparam int IN_CAP = 127;
  localparam int RANDOM_ITEMS = 1350;
  localparam int QUIET_LIMIT = 70000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic [1:0] REQ_NONE = 2'd3;

  typedef struct {
    logic [1:0]                 kind;
    logic [3:0]                 tap;
    logic signed [SAMPLE_W-1:0] value;
  } deconv_req_t;

  typedef struct {
    logic [ACC_W-1:0] sum;
    logic             last;
  } plane_out_t;

  typedef struct {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic                        clk = 1'b0;
  logic                        rst = 1'b1;
  logic                        start = 1'b0;
  logic                        busy;
  logic [1:0]                  req_type = REQ_WEIGHT;
  logic [3:0]                  weight_index = '0;
  logic signed [SAMPLE_W-1:0]  sample_value = '0;
  logic                        result_valid;
  logic signed [ACC_W-1:0]     result_value;
  logic                        last_of_plane;
  logic                        cfg_valid = 1'b0;
  logic                        cfg_ready;
  logic [CFG_IDX_W-1:0]        cfg_index = '0;
  logic [CFG_DATA_W-1:0]       cfg_data = '0;

  depthwise_deconv3x3_accumulator_unit #(
    .MAX_OUT_DIM(MAX_DIM)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .weight_index(weight_index),
    .sample_value(sample_value),
    .result_valid(result_valid),
    .result_value(result_value),
    .last_of_plane(last_of_plane),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic                       stride_sel = 1'b0;
  logic [6:0]                 in_rows = 7'd1;
  logic [6:0]                 in_cols = 7'd1;
  logic [7:0]                 out_rows = 8'd3;
  logic [7:0]                 out_cols = 8'd3;
  logic signed [SAMPLE_W-1:0] taps [KERNEL_TAPS];
  logic [ACC_W-1:0]           plane_sums [MAX_DIM*MAX_DIM];
  int                         pix_row = 0;
  int                         pix_col = 0;
  int                         drain_ptr = 0;
  plane_out_t                 plane_due [$];

  int mismatches = 0;

  task automatic flag_mismatch(input string what);
    mismatches++;
    if (mismatches <= 100) begin
      $display("[%0t] %s", $time, what);
    end
  endtask

  function automatic int clamp_dim(input int v, input int cap);
    if (v == 0) return 1;
    if (v > cap) return cap;
    return v;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_STRIDE_TWO: stride_sel = data[0];
      CFG_IN_HEIGHT:  in_rows = data[6:0];
      CFG_IN_WIDTH:   in_cols = data[6:0];
      CFG_OUT_HEIGHT: out_rows = data;
      CFG_OUT_WIDTH:  out_cols = data;
      default: ;
    endcase
  endfunction

  function automatic void deposit_pixel(input logic signed [SAMPLE_W-1:0] pix);
    int oh, ow, hop, orow, ocol, addr, r, c;
    logic signed [31:0] prod;
    oh = clamp_dim(out_rows, MAX_DIM);
    ow = clamp_dim(out_cols, MAX_DIM);
    hop = stride_sel ? 2 : 1;
    for (r = 0; r < 3; r++) begin
      for (c = 0; c < 3; c++) begin
        orow = hop * pix_row + r;
        ocol = hop * pix_col + c;
        if (orow < oh && ocol < ow) begin
          addr = orow * ow + ocol;
          prod = pix * taps[r*3+c];
          plane_sums[addr] = plane_sums[addr] + {{(ACC_W-32){prod[31]}}, prod};
        end
      end
    end
    pix_col++;
    if (pix_col >= clamp_dim(in_cols, IN_CAP)) begin
      pix_col = 0;
      pix_row++;
    end
    if (pix_row >= clamp_dim(in_rows, IN_CAP)) pix_row = 0;
  endfunction

  function automatic plane_out_t drain_element();
    plane_out_t o;
    int total;
    total = clamp_dim(out_rows, MAX_DIM) * clamp_dim(out_cols, MAX_DIM);
    if (drain_ptr >= total) drain_ptr = 0;
    o.sum = plane_sums[drain_ptr];
    plane_sums[drain_ptr] = '0;
    o.last = (drain_ptr + 1 == total);
    drain_ptr = o.last ? 0 : drain_ptr + 1;
    return o;
  endfunction

  function automatic void apply_request(input deconv_req_t rq);
    case (rq.kind)
      REQ_WEIGHT: if (rq.tap < KERNEL_TAPS) taps[rq.tap] = rq.value;
      REQ_PIXEL:  deposit_pixel(rq.value);
      REQ_READ:   plane_due.push_back(drain_element());
      default: ;
    endcase
  endfunction

  deconv_req_t req_q [$];
  deconv_req_t req_now;
  int          req_pushed = 0;
  int          req_taken = 0;
  int          gap_left = 0;
  bit          calm = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_request(req_now);
        req_taken++;
      end
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (req_q.size() > 0) begin
          req_now = req_q.pop_front();
          req_type <= req_now.kind;
          weight_index <= req_now.tap;
          sample_value <= req_now.value;
          start <= 1'b1;
          if (!calm && $urandom_range(0, 11) == 0) gap_left = $urandom_range(1, 19);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  reg_write_t reg_q [$];
  reg_write_t reg_now;
  int         reg_pushed = 0;
  int         reg_taken = 0;

  always @(posedge clk) begin
    if (rst) begin
      cfg_valid <= 1'b0;
    end else if (!cfg_valid || cfg_ready) begin
      if (cfg_valid) begin
        apply_register(cfg_index, cfg_data);
        reg_taken++;
      end
      if (reg_q.size() > 0) begin
        reg_now = reg_q.pop_front();
        cfg_index <= reg_now.idx;
        cfg_data <= reg_now.data;
        cfg_valid <= 1'b1;
      end else begin
        cfg_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : result_check
    plane_out_t want;
    if (!rst && result_valid) begin
      if (plane_due.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat, value %0d last %0b",
                                result_value, last_of_plane));
      end else begin
        want = plane_due.pop_front();
        if (result_value !== want.sum) begin
          flag_mismatch($sformatf("result_value %0d, want %0d",
                                  result_value, $signed(want.sum)));
        end
        if (last_of_plane !== want.last) begin
          flag_mismatch($sformatf("last_of_plane %0b, want %0b", last_of_plane, want.last));
        end
      end
    end
  end

  int quiet = 0;

  always @(posedge clk) begin
    if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  int stim_count = 0;

  task automatic push_req(input logic [1:0] kind, input logic [3:0] tap,
                          input logic signed [SAMPLE_W-1:0] value);
    deconv_req_t rq;
    rq.kind = kind;
    rq.tap = tap;
    rq.value = value;
    req_q.push_back(rq);
    req_pushed++;
    if (kind != REQ_NONE && !(kind == REQ_WEIGHT && tap >= KERNEL_TAPS)) stim_count++;
  endtask

  task automatic settle();
    while (req_taken != req_pushed || plane_due.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_regs(input logic st, input int ih, input int iw, input int oh,
                            input int ow);
    reg_write_t w [$];
    w.push_back('{CFG_STRIDE_TWO, {7'($urandom), st}});
    w.push_back('{CFG_IN_HEIGHT, {1'($urandom), 7'(ih)}});
    w.push_back('{CFG_IN_WIDTH, {1'($urandom), 7'(iw)}});
    w.push_back('{CFG_OUT_HEIGHT, 8'(oh)});
    w.push_back('{CFG_OUT_WIDTH, 8'(ow)});
    w.shuffle();
    foreach (w[k]) begin
      reg_q.push_back(w[k]);
      reg_pushed++;
    end
    while (reg_taken != reg_pushed) @(negedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 15))
      0, 1:    return 16'sh8000;
      2, 3:    return 16'sh7FFF;
      4:       return '0;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  function automatic int pick_in_dim();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return IN_CAP;
      2:       return $urandom_range(7, 126);
      default: return $urandom_range(1, 6);
    endcase
  endfunction

  function automatic int pick_out_dim();
    case ($urandom_range(0, 19))
      0:       return 0;
      1:       return $urandom_range(MAX_DIM + 1, 255);
      2:       return MAX_DIM;
      3:       return $urandom_range(15, MAX_DIM - 1);
      default: return $urandom_range(1, 14);
    endcase
  endfunction

  task automatic maybe_noise();
    case ($urandom_range(0, 39))
      0:       push_req(REQ_NONE, 4'($urandom), SAMPLE_W'($urandom));
      1:       push_req(REQ_WEIGHT, 4'($urandom_range(KERNEL_TAPS, 15)), SAMPLE_W'($urandom));
      2:       push_req(REQ_READ, 4'($urandom), SAMPLE_W'($urandom));
      default: ;
    endcase
  endtask

  task automatic run_plane(input logic st, input int ih, input int iw, input int oh,
                           input int ow, input bit reload, input int pix_cap,
                           input int read_cap);
    int order [$];
    int npix, nread;
    write_regs(st, ih, iw, oh, ow);
    if (reload) begin
      for (int t = 0; t < KERNEL_TAPS; t++) order.push_back(t);
      order.shuffle();
      foreach (order[k]) begin
        push_req(REQ_WEIGHT, 4'(order[k]), pick_sample());
        maybe_noise();
      end
    end
    npix = clamp_dim(ih, IN_CAP) * clamp_dim(iw, IN_CAP);
    if (npix > pix_cap) npix = $urandom_range(pix_cap / 3, pix_cap);
    repeat (npix) begin
      push_req(REQ_PIXEL, 4'($urandom), pick_sample());
      maybe_noise();
    end
    nread = clamp_dim(oh, MAX_DIM) * clamp_dim(ow, MAX_DIM);
    if (nread > read_cap) nread = $urandom_range(read_cap / 5, read_cap);
    repeat (nread) begin
      push_req(REQ_READ, 4'($urandom), SAMPLE_W'($urandom));
      maybe_noise();
    end
    settle();
  endtask

  initial begin
    foreach (taps[k]) taps[k] = '0;
    foreach (plane_sums[k]) plane_sums[k] = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    push_req(REQ_WEIGHT, 4'd0, 16'sh7FFF);
    push_req(REQ_WEIGHT, 4'd1, 16'sh8000);
    push_req(REQ_WEIGHT, 4'd2, 16'sd0);
    push_req(REQ_WEIGHT, 4'd3, 16'sd1);
    push_req(REQ_WEIGHT, 4'd4, -16'sd1);
    push_req(REQ_WEIGHT, 4'd5, 16'sd12345);
    push_req(REQ_WEIGHT, 4'd6, 16'sh8000);
    push_req(REQ_WEIGHT, 4'd7, 16'sh7FFF);
    push_req(REQ_WEIGHT, 4'd8, -16'sd2);
    push_req(REQ_WEIGHT, 4'd9, 16'sd7);
    push_req(REQ_WEIGHT, 4'd15, -16'sd1);
    push_req(REQ_NONE, 4'd15, 16'sh7FFF);
    push_req(REQ_PIXEL, 4'd0, 16'sh8000);
    push_req(REQ_PIXEL, 4'd15, 16'sh7FFF);
    repeat (10) push_req(REQ_READ, 4'($urandom), SAMPLE_W'($urandom));
    settle();

    run_plane(1'b0, IN_CAP, 1, 255, 1, 1'b1, 200, 200);
    run_plane(1'b1, 1, 126, 3, MAX_DIM, 1'b1, 200, 200);
    run_plane(1'b1, 126, 0, MAX_DIM, 0, 1'b0, 140, 200);

    // A single element fed the largest product many times over wraps the 36-bit sum.
    write_regs(1'b0, 0, 0, 0, 0);
    for (int t = 0; t < KERNEL_TAPS; t++) push_req(REQ_WEIGHT, 4'(t), 16'sh8000);
    repeat (40) push_req(REQ_PIXEL, 4'($urandom), 16'sh8000);
    push_req(REQ_READ, 4'($urandom), SAMPLE_W'($urandom));
    settle();

    while (stim_count < RANDOM_ITEMS) begin
      if (stim_count > RANDOM_ITEMS - 200) calm = 1'b1;
      run_plane(1'($urandom), pick_in_dim(), pick_in_dim(), pick_out_dim(), pick_out_dim(),
                $urandom_range(0, 3) != 0, 60, 150);
    end
    settle();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/dwdc_pkg.sv
rtl/core/dwdc_ram.sv
rtl/core/dwdc_mult.sv
rtl/core/depthwise_deconv3x3_accumulator_unit.sv
dv/testbench.sv
